// ===== hw/rtl/lcac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcac_pkg
// Shared types and constants for the lru cache access cost unit.
// ----------------------------------------------------------------------------
package lcac_pkg;

    localparam int KEY_WIDTH  = 32;
    localparam int CFG_WIDTH  = 6;
    localparam int COST_WIDTH = 3;
    localparam int SUM_WIDTH  = 32;

    localparam logic [COST_WIDTH-1:0] HIT_COST  = 3'd1;
    localparam logic [COST_WIDTH-1:0] MISS_COST = 3'd5;
    localparam logic [SUM_WIDTH-1:0]  SUM_MAX   = 32'hFFFF_FFFF;

    // one access item
    typedef struct packed {
        logic [KEY_WIDTH-1:0] city_key;
        logic                 start_new;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic                  hit;
        logic [COST_WIDTH-1:0] access_cost;
        logic [SUM_WIDTH-1:0]  total_cost;
    } out_item_t;

    // control from the top level to the lookup engine
    typedef struct packed {
        logic                 start;
        logic                 start_new;
        logic [CFG_WIDTH-1:0] cache_size;
        logic                 take;
    } eng_req_t;

    // status from the lookup engine to the top level
    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
    } eng_rsp_t;

endpackage

// ===== hw/rtl/lcac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcac_ram
// Generic simple dual-port ram, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module lcac_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/lcac_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcac_engine
// Lookup and recency engine: a scan pass over the entry memory finds the hit,
// free slot and victim, then a write-back pass ages entries and installs the key.
// ----------------------------------------------------------------------------
module lcac_engine #(
    parameter int ENTRIES   = 32,
    parameter int TAG_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcac_pkg::eng_req_t   req,
    input  logic [TAG_WIDTH-1:0] key,
    output lcac_pkg::eng_rsp_t   rsp
);

    import lcac_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int REC_W = IDX_W;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int MEM_W = TAG_WIDTH + REC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [ENTRIES-1:0]   valid_reg;
    logic [TAG_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic                 rv_reg;
    logic                 rlast_reg;
    logic [IDX_W-1:0]     ridx_reg;
    logic                 hit_reg;

    // scan trackers
    logic                 found_reg;
    logic [IDX_W-1:0]     found_idx_reg;
    logic [REC_W-1:0]     found_rec_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 victim_found_reg;
    logic [IDX_W-1:0]     victim_idx_reg;
    logic [REC_W-1:0]     victim_rec_reg;

    // write-back plan
    logic [IDX_W-1:0]     slot_reg;
    logic [REC_W-1:0]     limit_reg;
    logic                 age_all_reg;

    logic                 issue_go;
    logic [IDX_W-1:0]     issue_idx;
    logic                 last_data;
    logic [CNT_W-1:0]     cap_now;
    logic                 rd_vbit;
    logic [TAG_WIDTH-1:0] rd_tag;
    logic [REC_W-1:0]     rd_rec;
    logic [MEM_W-1:0]     rdata;
    logic                 ram_we;
    logic [MEM_W-1:0]     ram_wdata;

    // entry memory: tag and recency rank per entry
    lcac_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ridx_reg),
        .wdata (ram_wdata),
        .raddr (issue_idx),
        .rdata (rdata)
    );

    // read pipe shared by both passes
    assign issue_go  = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                       && (issue_reg < CNT_W'(ENTRIES));
    assign issue_idx = issue_reg[IDX_W-1:0];
    assign last_data = rv_reg && rlast_reg;
    assign rd_tag    = rdata[MEM_W-1:REC_W];
    assign rd_rec    = rdata[REC_W-1:0];
    assign rd_vbit   = valid_reg[ridx_reg];

    // capacity clipped to the number of entries
    always_comb begin
        if (32'(req.cache_size) > 32'(ENTRIES)) begin
            cap_now = CNT_W'(ENTRIES);
        end else begin
            cap_now = CNT_W'(req.cache_size);
        end
    end

    // write-back: install key at the slot, age the younger valid entries on a hit or all of them on a miss
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = {rd_tag, REC_W'(rd_rec + 1'b1)};
        if ((state_reg == ST_UPDATE) && rv_reg) begin
            if (ridx_reg == slot_reg) begin
                ram_we    = 1'b1;
                ram_wdata = {key_reg, {REC_W{1'b0}}};
            end else if (rd_vbit && (age_all_reg || (rd_rec < limit_reg))) begin
                ram_we = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    state_next = (cap_now == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_data) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (last_data) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (req.take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, read pipe, trackers and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            issue_reg <= '0;
            rv_reg    <= 1'b0;
            rlast_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= issue_go;
            rlast_reg <= issue_go && (issue_reg == CNT_W'(ENTRIES - 1));
            ridx_reg  <= issue_idx;
            if (issue_go) begin
                issue_reg <= issue_reg + 1'b1;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        key_reg          <= key;
                        cap_reg          <= cap_now;
                        issue_reg        <= '0;
                        hit_reg          <= 1'b0;
                        found_reg        <= 1'b0;
                        count_reg        <= '0;
                        free_found_reg   <= 1'b0;
                        victim_found_reg <= 1'b0;
                        if (req.start_new) begin
                            valid_reg <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (rv_reg) begin
                        if (rd_vbit) begin
                            count_reg <= count_reg + 1'b1;
                            if (!found_reg && (rd_tag == key_reg)) begin
                                found_reg     <= 1'b1;
                                found_idx_reg <= ridx_reg;
                                found_rec_reg <= rd_rec;
                            end
                            if (!victim_found_reg || (rd_rec > victim_rec_reg)) begin
                                victim_found_reg <= 1'b1;
                                victim_idx_reg   <= ridx_reg;
                                victim_rec_reg   <= rd_rec;
                            end
                        end else if (!free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= ridx_reg;
                        end
                    end
                end
                ST_DECIDE: begin
                    issue_reg <= '0;
                    priority if (found_reg) begin
                        hit_reg     <= 1'b1;
                        slot_reg    <= found_idx_reg;
                        limit_reg   <= found_rec_reg;
                        age_all_reg <= 1'b0;
                    end else if ((count_reg < cap_reg) && free_found_reg) begin
                        slot_reg                <= free_idx_reg;
                        valid_reg[free_idx_reg] <= 1'b1;
                        age_all_reg             <= 1'b1;
                    end else begin
                        slot_reg    <= victim_idx_reg;
                        age_all_reg <= 1'b1;
                    end
                end
                ST_UPDATE: begin
                end
                ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign rsp.ready = (state_reg == ST_IDLE);
    assign rsp.done  = (state_reg == ST_DONE);
    assign rsp.hit   = hit_reg;

`ifndef SYNTHESIS
    // memory is written only during the write-back pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_UPDATE))
        else $error("entry memory written outside write-back pass");

    // the chosen slot holds a valid entry through the write-back pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |=> valid_reg[slot_reg])
        else $error("chosen slot not valid after decision");

    // a finished result waits unchanged until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.done && !req.take) |=> (rsp.done && $stable(hit_reg)))
        else $error("finished result dropped or changed before take");

    // neither pass starts new reads after its last one
    assert property (@(posedge aclk) disable iff (!aresetn)
        last_data |=> !rv_reg)
        else $error("read pipe not drained after last entry");
`endif

endmodule

// ===== hw/rtl/lru_cache_access_cost_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_access_cost_unit
// Fully associative lru cache model that reports hit, access cost and a
// saturating running total for each key access.
// ----------------------------------------------------------------------------
// An accepted access runs a scan pass, a decision state and a write-back
// pass before its result lands in the output register, or skips the passes
// when cache_size is zero. The next item is accepted only once that result
// is taken, so an access never overlaps the one before it.
// The pace is set by the entry memory's single read port: every access runs
// one scan pass over all entries (tag compare, free slot and oldest entry) and
// one write-back pass (recency aging and key install), one entry a cycle each.
// A finished access waits while the output register holds a result that is
// not taken, and the input stalls for that time. Entry valid bits are
// flip-flops, so no clearing pass follows reset and start_new clears the
// cache at once.
module lru_cache_access_cost_unit #(
    parameter int ENTRIES   = 32,
    parameter int TAG_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lcac_pkg::in_item_t                 s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lcac_pkg::out_item_t                m_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lcac_pkg::CFG_WIDTH-1:0]     cfg_data
);

    import lcac_pkg::*;

    logic [CFG_WIDTH-1:0]  cache_size_reg;
    logic [SUM_WIDTH-1:0]  sum_reg;
    logic                  m_valid_reg;
    out_item_t             m_item_reg;

    eng_req_t              req;
    eng_rsp_t              rsp;
    logic                  s_accept;
    logic [COST_WIDTH-1:0] cost;
    logic [SUM_WIDTH:0]    sum_wide;
    logic [SUM_WIDTH-1:0]  sum_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = rsp.ready;
    assign s_accept  = s_valid && rsp.ready;

    // engine control
    assign req.start      = s_accept;
    assign req.start_new  = s_item.start_new;
    assign req.cache_size = cache_size_reg;
    assign req.take       = rsp.done && (!m_valid_reg || m_ready);

    lcac_engine #(
        .ENTRIES   (ENTRIES),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .key     (TAG_WIDTH'(s_item.city_key)),
        .rsp     (rsp)
    );

    // cost and saturating total
    assign cost     = rsp.hit ? HIT_COST : MISS_COST;
    assign sum_wide = {1'b0, sum_reg} + (SUM_WIDTH + 1)'(cost);
    assign sum_next = sum_wide[SUM_WIDTH] ? SUM_MAX : sum_wide[SUM_WIDTH-1:0];

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cache_size_reg <= '0;
            sum_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cache_size_reg <= cfg_data;
            end
            if (s_accept && s_item.start_new) begin
                sum_reg <= '0;
            end else if (req.take) begin
                sum_reg <= sum_next;
            end
            if (req.take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output item register
    always_ff @(posedge aclk) begin
        if (req.take) begin
            m_item_reg.hit         <= rsp.hit;
            m_item_reg.access_cost <= cost;
            m_item_reg.total_cost  <= sum_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTHESIS
    // reported cost matches the hit flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_item_reg.hit && (m_item_reg.access_cost == HIT_COST))
                      || (!m_item_reg.hit && (m_item_reg.access_cost == MISS_COST))))
        else $error("access cost does not match hit flag");

    // total moves only on a start_new clear or a finished access
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_accept && !req.take) |=> $stable(sum_reg))
        else $error("running total changed without an access");

    // a finished access always lands in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.take |=> (m_valid_reg && (m_item_reg.total_cost == sum_reg)))
        else $error("result not loaded with current total");
`endif

endmodule

// ===== verif/lru_cache_access_cost_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_access_cost_unit_tb
// Self-checking bench for the lru cache access cost unit. A queue-fed driver
// offers key accesses, a scoreboard model of the lru cache predicts hit, cost
// and running total per access, and a monitor checks every result in order.
// The run steps through many cache sizes, including zero, oversized and
// shrunk capacities, with random stalls on both channels.
// ----------------------------------------------------------------------------
module lru_cache_access_cost_unit_tb;

    import lcac_pkg::*;

    localparam int ENTRIES   = 32;
    localparam int TAG_WIDTH = 32;
    localparam int POOL      = 48;
    localparam int PHASES    = 12;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_WIDTH-1:0] cfg_data  = '0;

    // scoreboard copy of the cache
    logic [KEY_WIDTH-1:0] tag_mem   [ENTRIES];
    bit                   valid_mem [ENTRIES];
    int unsigned          age_mem   [ENTRIES];
    logic [SUM_WIDTH-1:0] run_total;
    logic [CFG_WIDTH-1:0] size_cfg;

    in_item_t             access_q   [$];
    out_item_t            cost_due_q [$];
    logic [KEY_WIDTH-1:0] key_pool   [POOL];

    bit no_idle = 1'b0;
    int send_gap;
    int recv_gap;
    int hold_left;
    int sent_cnt     = 0;
    int rx_cnt       = 0;
    int hit_cnt      = 0;
    int mismatch_cnt = 0;

    lru_cache_access_cost_unit #(
        .ENTRIES   (ENTRIES),
        .TAG_WIDTH (TAG_WIDTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // empty the cache and restart the total
    function automatic void clear_cache();
        for (int i = 0; i < ENTRIES; i++) begin
            tag_mem[i]   = '0;
            valid_mem[i] = 1'b0;
            age_mem[i]   = 0;
        end
        run_total = '0;
    endfunction

    // age valid entries younger than limit, then make slot the newest
    function automatic void age_entries(int slot, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (valid_mem[i] && i != slot && age_mem[i] < limit) begin
                age_mem[i]++;
            end
        end
        age_mem[slot] = 0;
    endfunction

    // one access against the scoreboard cache, returns the expected result
    function automatic out_item_t lookup_cost(in_item_t acc);
        int                    found;
        int                    free_slot;
        int                    victim;
        int unsigned           count;
        int unsigned           oldest;
        int unsigned           cap;
        bit                    hit;
        logic [COST_WIDTH-1:0] cost;
        out_item_t             res;
        found     = -1;
        free_slot = -1;
        victim    = -1;
        count     = 0;
        oldest    = 0;
        hit       = 1'b0;
        cap       = (size_cfg > ENTRIES) ? ENTRIES : size_cfg;
        if (acc.start_new) begin
            clear_cache();
        end
        if (cap != 0) begin
            // scan for the key, a free entry and the oldest entry
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_mem[i]) begin
                    count++;
                    if (found < 0 && tag_mem[i] == acc.city_key) found = i;
                    if (victim < 0 || age_mem[i] > oldest) begin
                        victim = i;
                        oldest = age_mem[i];
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (found >= 0) begin
                hit = 1'b1;
                age_entries(found, age_mem[found]);
            end else if (count < cap && free_slot >= 0) begin
                tag_mem[free_slot]   = acc.city_key;
                valid_mem[free_slot] = 1'b1;
                age_entries(free_slot, 32'hFFFF);
            end else if (victim >= 0) begin
                tag_mem[victim] = acc.city_key;
                age_entries(victim, 32'hFFFF);
            end
        end
        cost = hit ? HIT_COST : MISS_COST;
        // saturating running total
        if (run_total > SUM_MAX - {{(SUM_WIDTH-COST_WIDTH){1'b0}}, cost}) begin
            run_total = SUM_MAX;
        end else begin
            run_total = run_total + cost;
        end
        res.hit         = hit;
        res.access_cost = cost;
        res.total_cost  = run_total;
        return res;
    endfunction

    // idle length for one side: nonzero about 18 times in a hundred, zero with no_idle
    function automatic int idle_draw();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 18) return 1;
        return 0;
    endfunction

    // driver: offers pending items, predicts each one on acceptance
    always @(posedge aclk) begin : drive_items
        bit take_next;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            take_next = !s_valid;
            if (s_valid && s_ready) begin
                cost_due_q.push_back(lookup_cost(s_item));
                sent_cnt++;
                take_next = 1'b1;
            end
            if (take_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (access_q.size() != 0) begin
                    send_gap = idle_draw();
                    if (send_gap == 0) begin
                        s_valid <= 1'b1;
                        s_item  <= access_q.pop_front();
                    end else begin
                        send_gap--;
                        s_valid <= 1'b0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results in order and drives result backpressure
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (cost_due_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %p", $time, m_item);
                    mismatch_cnt++;
                end else begin
                    want = cost_due_q.pop_front();
                    if (m_item.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, want.hit, m_item.hit);
                        mismatch_cnt++;
                    end
                    if (m_item.access_cost !== want.access_cost) begin
                        $display("%0t: access_cost mismatch, expected %0d, got %0d",
                                 $time, want.access_cost, m_item.access_cost);
                        mismatch_cnt++;
                    end
                    if (m_item.total_cost !== want.total_cost) begin
                        $display("%0t: total_cost mismatch, expected %0d, got %0d",
                                 $time, want.total_cost, m_item.total_cost);
                        mismatch_cnt++;
                    end
                    rx_cnt++;
                    if (want.hit) hit_cnt++;
                    // long hold-off so the block backs up into its input
                    if (rx_cnt == 300 || rx_cnt == 1200) hold_left = 400;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                recv_gap = idle_draw();
                m_ready <= (recv_gap == 0);
                if (recv_gap > 0) recv_gap--;
            end
        end
    end

    // wait until every item is sent and every result is back
    task automatic drain();
        @(negedge aclk);
        while (access_q.size() != 0 || s_valid || cost_due_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // write cache_size while the block is idle
    task automatic set_size(logic [CFG_WIDTH-1:0] value);
        drain();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_cfg  = value;
        @(negedge aclk);
    endtask

    task automatic queue_access(logic [KEY_WIDTH-1:0] key, logic sn);
        in_item_t it;
        it.city_key  = key;
        it.start_new = sn;
        access_q.push_back(it);
    endtask

    // random accesses, keys mostly from a window of the pool sized to the cache
    task automatic fill_random(int n);
        int       cap;
        int       win;
        in_item_t it;
        cap = (size_cfg > ENTRIES) ? ENTRIES : size_cfg;
        win = cap + $urandom_range(1, 6);
        if (win > POOL) win = POOL;
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                it.city_key = $urandom();
            end else begin
                it.city_key = key_pool[$urandom_range(0, win - 1)];
            end
            it.start_new = ($urandom_range(0, 79) == 0);
            access_q.push_back(it);
        end
    endtask

    initial begin : stimulus
        int sizes [PHASES];
        sizes = '{32, 63, 2, 8, 0, 33, 16, 1, 31, 5, 3, 32};
        clear_cache();
        size_cfg = '0;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // small cache: fill, hit refresh, lru eviction, restart
        set_size(6'd4);
        queue_access(32'h0000_0000, 1'b1);
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'hFFFF_FFFF, 1'b0);
        queue_access(32'h0000_0001, 1'b0);
        queue_access(32'h0000_0002, 1'b0);
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'h0000_0003, 1'b0);
        queue_access(32'hFFFF_FFFF, 1'b0);
        queue_access(32'hAAAA_AAAA, 1'b0);
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'h5555_5555, 1'b1);
        queue_access(32'h5555_5555, 1'b0);
        queue_access(32'h0000_0001, 1'b0);
        queue_access(32'h0000_0002, 1'b0);
        queue_access(32'h0000_0003, 1'b0);

        // zero capacity: all misses, contents left alone
        set_size(6'd0);
        queue_access(32'h0000_0002, 1'b0);
        queue_access(32'hFFFF_FFFF, 1'b0);

        // shrunk capacity: old entries still hit, misses replace the oldest
        set_size(6'd1);
        queue_access(32'h0000_0002, 1'b0);
        queue_access(32'h0000_0003, 1'b0);
        queue_access(32'h0000_0007, 1'b0);
        queue_access(32'h0000_0001, 1'b0);

        // random phases over many sizes, one of them with no idling
        for (int p = 0; p < PHASES; p++) begin
            set_size(CFG_WIDTH'(sizes[p]));
            no_idle = (p == 6);
            fill_random(155);
        end

        drain();
        repeat (80) @(posedge aclk);
        $display("accesses checked: %0d (%0d hits, %0d misses)",
                 rx_cnt, hit_cnt, rx_cnt - hit_cnt);
        $display("cache sizes exercised: %0d phases incl. zero, oversized and shrunk",
                 PHASES + 3);
        if (mismatch_cnt == 0) begin
            $display("lru_cache_access_cost_unit_tb passed");
        end else begin
            $display("lru_cache_access_cost_unit_tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #50_000_000;
        $display("lru_cache_access_cost_unit_tb failed");
        $finish;
    end

endmodule

// ===== lru_cache_access_cost_unit.f =====
hw/rtl/lcac_pkg.sv
hw/rtl/lcac_ram.sv
hw/rtl/lcac_engine.sv
hw/rtl/lru_cache_access_cost_unit.sv
verif/lru_cache_access_cost_unit_tb.sv
